[hw/rtl/fih_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fih_pkg
// Shared types and constants of the flux interval histogram.
// ----------------------------------------------------------------------------
package fih_pkg;

  // Operation codes carried on the input word.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } fih_op_t;

  // Sequencer states of the back end.
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } fih_state_t;

  // Classified command as it sits in the queue (the bin address travels
  // beside it, since its width follows the bin count).
  typedef struct packed {
    fih_op_t     op;
    logic        ovf;       // interval landed in the last bin
    logic        oob;       // read beyond the last bin
    logic [15:0] interval;
  } fih_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fih_q_status_t;

  typedef struct packed {
    logic sweeping;         // bin store clearing pass in progress
    logic exec;             // command being retired this cycle
  } fih_bk_status_t;

  localparam int unsigned MEAN_SHIFT = 4;
  localparam logic [15:0] BIN_MAX    = 16'hFFFF;
  localparam logic [15:0] LOW_RESET  = 16'hFFFF;
  localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;

endpackage : fih_pkg
`default_nettype wire

[hw/rtl/fih_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fih_queue
// Small register FIFO between the classifier and the executing back end.
// ----------------------------------------------------------------------------
module fih_queue
  import fih_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output fih_q_status_t         status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data    = slot_r[rd_ptr_r];
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule : fih_queue
`default_nettype wire

[hw/rtl/fih_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fih_front
// Input handshake and classification: bins the interval, flags overflow and
// out-of-range reads, and pushes the command into the queue.
// ----------------------------------------------------------------------------
module fih_front
  import fih_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned SLOT_SHIFT = 2,
  parameter int unsigned AW         = 8
) (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_opcode,
  input  wire logic [15:0]   in_interval,
  input  wire logic [7:0]    in_bin_index,
  input  wire fih_q_status_t q_status,
  input  wire fih_bk_status_t bk_status,
  output logic               q_push,
  output fih_cmd_t           q_cmd,
  output logic [AW-1:0]      q_addr
);

  localparam logic [15:0] LAST_BIN = 16'(NUM_BINS - 1);

  logic [15:0] slot_full;
  logic        read_oob;

  always_comb begin
    slot_full = in_interval >> SLOT_SHIFT;
    read_oob  = (32'(in_bin_index) >= 32'(NUM_BINS));

    q_cmd.op       = fih_op_t'(in_opcode);
    q_cmd.interval = in_interval;
    q_cmd.ovf      = (slot_full >= LAST_BIN);
    q_cmd.oob      = read_oob;

    case (q_cmd.op)
      OP_ADD:  q_addr = q_cmd.ovf ? AW'(NUM_BINS - 1) : slot_full[AW-1:0];
      OP_READ: q_addr = read_oob ? '0 : AW'(in_bin_index);
      default: q_addr = '0;
    endcase
  end

  // Nothing is taken while the queue is full or the bin store is being swept.
  assign in_stall = q_status.full | bk_status.sweeping;
  assign q_push   = in_valid & ~in_stall;

endmodule : fih_front
`default_nettype wire

[hw/rtl/fih_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fih_back
// Executes queued commands: read-modify-write of the bin store, running
// statistics, clearing pass, and the result register.
// ----------------------------------------------------------------------------
module fih_back
  import fih_pkg::*;
#(
  parameter int unsigned NUM_BINS = 256,
  parameter int unsigned AW       = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fih_q_status_t q_status,
  input  wire fih_cmd_t      q_cmd,
  input  wire logic [AW-1:0] q_addr,
  output logic               q_pop,
  output fih_bk_status_t     bk_status,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_bin_count,
  output logic [31:0]        out_sample_total,
  output logic [15:0]        out_shortest_interval,
  output logic [15:0]        out_longest_interval,
  output logic [31:0]        out_overflow_total,
  output logic [7:0]         out_peak_index,
  output logic [15:0]        out_peak_value,
  output logic [15:0]        out_mean_estimate
);

  fih_state_t     state_r, state_nxt;
  logic [AW-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic           sweep_we, exec, out_free;

  fih_cmd_t       cur_cmd_r;
  logic [AW-1:0]  cur_addr_r;

  logic [15:0]    mem [NUM_BINS];
  logic [15:0]    rd_data_r;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  logic [15:0]    mem_wd;

  logic [31:0]    sample_cnt_r,  sample_cnt_nxt;
  logic [15:0]    low_mark_r,    low_mark_nxt;
  logic [15:0]    high_mark_r,   high_mark_nxt;
  logic [31:0]    ovf_cnt_r,     ovf_cnt_nxt;
  logic [AW-1:0]  peak_slot_r,   peak_slot_nxt;
  logic [15:0]    peak_level_r,  peak_level_nxt;
  logic [15:0]    mean_r,        mean_nxt;
  logic [15:0]    bin_count_r,   bin_count_nxt;
  logic           out_valid_r,   out_valid_nxt;

  logic [15:0]    bin_inc;
  logic           bin_sat;

  // The result register must be empty by the time the command retires.
  assign out_free = ~out_valid_r | ~out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: if (sweep_cnt_r == AW'(NUM_BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (!q_status.empty && out_free) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = (cur_cmd_r.op == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
      default:  state_nxt = ST_SWEEP;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    sweep_we = 1'b0;
    q_pop    = 1'b0;
    exec     = 1'b0;
    case (state_r)
      ST_SWEEP: sweep_we = 1'b1;
      ST_IDLE:  q_pop    = ~q_status.empty & out_free;
      ST_EXEC:  exec     = 1'b1;
      default:  sweep_we = 1'b0;
    endcase
  end

  always_comb begin
    sweep_cnt_nxt = sweep_we ? sweep_cnt_r + AW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd_r  <= q_cmd;
      cur_addr_r <= q_addr;
    end
  end

  // Bin store: one write port, one registered read port.
  assign bin_inc = rd_data_r + 16'd1;
  assign bin_sat = (rd_data_r == BIN_MAX);

  always_comb begin
    mem_we = sweep_we | (exec & (cur_cmd_r.op == OP_ADD) & ~bin_sat);
    mem_wa = sweep_we ? sweep_cnt_r : cur_addr_r;
    mem_wd = sweep_we ? '0 : bin_inc;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_addr];
    end
  end

  // Statistics update at retirement.
  always_comb begin
    sample_cnt_nxt = sample_cnt_r;
    low_mark_nxt   = low_mark_r;
    high_mark_nxt  = high_mark_r;
    ovf_cnt_nxt    = ovf_cnt_r;
    peak_slot_nxt  = peak_slot_r;
    peak_level_nxt = peak_level_r;
    mean_nxt       = mean_r;
    bin_count_nxt  = bin_count_r;
    if (exec) begin
      bin_count_nxt = '0;
      case (cur_cmd_r.op)
        OP_ADD: begin
          if (sample_cnt_r != CNT_MAX) sample_cnt_nxt = sample_cnt_r + 32'd1;
          if (cur_cmd_r.interval < low_mark_r)  low_mark_nxt  = cur_cmd_r.interval;
          if (cur_cmd_r.interval > high_mark_r) high_mark_nxt = cur_cmd_r.interval;
          if (cur_cmd_r.ovf && ovf_cnt_r != CNT_MAX) ovf_cnt_nxt = ovf_cnt_r + 32'd1;
          if (!bin_sat && bin_inc > peak_level_r) begin
            peak_slot_nxt  = cur_addr_r;
            peak_level_nxt = bin_inc;
          end
          mean_nxt = mean_r - (mean_r >> MEAN_SHIFT) + (cur_cmd_r.interval >> MEAN_SHIFT);
        end
        OP_READ: begin
          bin_count_nxt = cur_cmd_r.oob ? '0 : rd_data_r;
        end
        OP_CLEAR: begin
          sample_cnt_nxt = '0;
          low_mark_nxt   = LOW_RESET;
          high_mark_nxt  = '0;
          ovf_cnt_nxt    = '0;
          peak_slot_nxt  = '0;
          peak_level_nxt = '0;
          mean_nxt       = '0;
        end
        default: bin_count_nxt = '0;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (exec)                      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '0;
      low_mark_r   <= LOW_RESET;
      high_mark_r  <= '0;
      ovf_cnt_r    <= '0;
      peak_slot_r  <= '0;
      peak_level_r <= '0;
      mean_r       <= '0;
      bin_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      sample_cnt_r <= sample_cnt_nxt;
      low_mark_r   <= low_mark_nxt;
      high_mark_r  <= high_mark_nxt;
      ovf_cnt_r    <= ovf_cnt_nxt;
      peak_slot_r  <= peak_slot_nxt;
      peak_level_r <= peak_level_nxt;
      mean_r       <= mean_nxt;
      bin_count_r  <= bin_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Statistics change only when a command retires, which is also when the
  // result register loads, so they can feed the result word directly.
  assign out_valid             = out_valid_r;
  assign out_bin_count         = bin_count_r;
  assign out_sample_total      = sample_cnt_r;
  assign out_shortest_interval = low_mark_r;
  assign out_longest_interval  = high_mark_r;
  assign out_overflow_total    = ovf_cnt_r;
  assign out_peak_index        = 8'(peak_slot_r);
  assign out_peak_value        = peak_level_r;
  assign out_mean_estimate     = mean_r;

  assign bk_status.sweeping = (state_r == ST_SWEEP);
  assign bk_status.exec     = exec;

endmodule : fih_back
`default_nettype wire

[hw/rtl/flux_interval_histogram.sv]
`default_nettype none
// Flow: an accepted word is written into the queue; the back end pops it once
//   the result register is free, and out_valid rises as the command retires.
// Pace: the back end takes one command at a time, reading the bin into a
//   register and writing it back before it pops the next; words queue meanwhile.
// Reset: synchronous, active low; afterwards a clearing pass over all NUM_BINS
//   bins zeroes the store with in_stall high. A clear word runs the same pass.
// ----------------------------------------------------------------------------
// flux_interval_histogram
// Histogram of flux-transition intervals with peak tracking, min/max marks,
// saturating sample and overflow counts, and a running mean.
// ----------------------------------------------------------------------------
module flux_interval_histogram
  import fih_pkg::*;
#(
  parameter int unsigned NUM_BINS   = 256,
  parameter int unsigned SLOT_SHIFT = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_interval,
  input  wire logic [7:0]  in_bin_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_bin_count,
  output logic [31:0]      out_sample_total,
  output logic [15:0]      out_shortest_interval,
  output logic [15:0]      out_longest_interval,
  output logic [31:0]      out_overflow_total,
  output logic [7:0]       out_peak_index,
  output logic [15:0]      out_peak_value,
  output logic [15:0]      out_mean_estimate
);

  // Address width of the bin store.
  localparam int unsigned AW    = $clog2(NUM_BINS);
  // A queue entry is the classified command plus its bin address.
  localparam int unsigned CMD_W = $bits(fih_cmd_t);
  localparam int unsigned QW    = CMD_W + AW;
  localparam int unsigned QDEPTH = 2;

  fih_q_status_t  q_status;
  fih_bk_status_t bk_status;
  logic           q_push, q_pop;
  fih_cmd_t       push_cmd, head_cmd;
  logic [AW-1:0]  push_addr, head_addr;
  logic [QW-1:0]  head_data;

  // The front end classifies each word as it is taken: the bin slot and the
  // overflow flag for samples, the range check for reads.
  fih_front #(
    .NUM_BINS   (NUM_BINS),
    .SLOT_SHIFT (SLOT_SHIFT),
    .AW         (AW)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_interval  (in_interval),
    .in_bin_index (in_bin_index),
    .q_status     (q_status),
    .bk_status    (bk_status),
    .q_push       (q_push),
    .q_cmd        (push_cmd),
    .q_addr       (push_addr)
  );

  // Two-entry queue: the front keeps taking words while a result word waits
  // on a stalled output.
  fih_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_cmd, push_addr}),
    .pop       (q_pop),
    .head_data (head_data),
    .status    (q_status)
  );

  assign head_cmd  = fih_cmd_t'(head_data[QW-1:AW]);
  assign head_addr = head_data[AW-1:0];

  // The back end reads the bin into a register and writes it back in the next
  // cycle, updating the statistics and loading the result word as it retires.
  fih_back #(
    .NUM_BINS (NUM_BINS),
    .AW       (AW)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_status              (q_status),
    .q_cmd                 (head_cmd),
    .q_addr                (head_addr),
    .q_pop                 (q_pop),
    .bk_status             (bk_status),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bin_count         (out_bin_count),
    .out_sample_total      (out_sample_total),
    .out_shortest_interval (out_shortest_interval),
    .out_longest_interval  (out_longest_interval),
    .out_overflow_total    (out_overflow_total),
    .out_peak_index        (out_peak_index),
    .out_peak_value        (out_peak_value),
    .out_mean_estimate     (out_mean_estimate)
  );

  // The back end only takes a command that the queue holds.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue popped while empty");

  // A retiring command never overwrites a result word still waiting.
  a_retire_free : assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.exec |-> !out_valid)
    else $error("result word overwritten");

  // Once a sample is counted the shortest interval cannot exceed the longest.
  a_marks_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_sample_total != 32'd0 |-> out_shortest_interval <= out_longest_interval)
    else $error("interval marks out of order");

  // No command retires during the clearing pass.
  a_sweep_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    bk_status.sweeping |-> !q_pop && !bk_status.exec)
    else $error("command executed during clearing pass");

endmodule : flux_interval_histogram
`default_nettype wire

[tb/sv/flux_interval_histogram_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_interval_histogram_tb
// Self-checking bench for the flux interval histogram. A queue-fed driver
// offers command words with random gaps, a monitor stalls the result side at
// random, and every accepted word is run through a local histogram model
// whose statistics are compared field by field with the result words.
// ----------------------------------------------------------------------------
module flux_interval_histogram_tb;
  import fih_pkg::*;

  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned SLOT_SHIFT = 2;
  localparam logic [7:0]  LAST_BIN   = 8'(NUM_BINS - 1);
  // Length of the back-to-back burst of adds into one bin.
  localparam int          BURST_ADDS = 120;
  localparam int          MAX_SHOWN  = 40;

  // One command word as the driver sees it. A word with hold_for_drain set
  // is not sent; it only makes the driver pause until every outstanding
  // result word has come back.
  typedef struct {
    fih_op_t     op;
    logic [15:0] interval;
    logic [7:0]  bin_index;
    logic        quiet;
    logic        hold_for_drain;
  } flux_word_t;

  // Statistics carried by one result word.
  typedef struct {
    logic [15:0] bin_count;
    logic [31:0] sample_total;
    logic [15:0] shortest_interval;
    logic [15:0] longest_interval;
    logic [31:0] overflow_total;
    logic [7:0]  peak_index;
    logic [15:0] peak_value;
    logic [15:0] mean_estimate;
  } flux_stats_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode    = 2'd0;
  logic [15:0] in_interval  = 16'd0;
  logic [7:0]  in_bin_index = 8'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_bin_count;
  logic [31:0] out_sample_total;
  logic [15:0] out_shortest_interval;
  logic [15:0] out_longest_interval;
  logic [31:0] out_overflow_total;
  logic [7:0]  out_peak_index;
  logic [15:0] out_peak_value;
  logic [15:0] out_mean_estimate;

  flux_interval_histogram #(
    .NUM_BINS   (NUM_BINS),
    .SLOT_SHIFT (SLOT_SHIFT)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_opcode             (in_opcode),
    .in_interval           (in_interval),
    .in_bin_index          (in_bin_index),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bin_count         (out_bin_count),
    .out_sample_total      (out_sample_total),
    .out_shortest_interval (out_shortest_interval),
    .out_longest_interval  (out_longest_interval),
    .out_overflow_total    (out_overflow_total),
    .out_peak_index        (out_peak_index),
    .out_peak_value        (out_peak_value),
    .out_mean_estimate     (out_mean_estimate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words waiting to be offered, and statistics waiting to be seen.
  flux_word_t  word_queue[$];
  flux_stats_t expected_stats[$];

  // Local copy of the histogram state.
  logic [15:0] hist_bins [NUM_BINS];
  logic [31:0] hist_samples;
  logic [15:0] hist_low;
  logic [15:0] hist_high;
  logic [31:0] hist_overflows;
  logic [7:0]  hist_peak_slot;
  logic [15:0] hist_peak_level;
  logic [15:0] hist_mean;

  int   mismatches  = 0;
  int   words_in    = 0;
  int   hold_left   = 0;
  logic hold_done   = 1'b0;
  logic quiet_phase = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_SHOWN)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_histogram();
    foreach (hist_bins[i]) hist_bins[i] = 16'd0;
    hist_samples    = 32'd0;
    hist_low        = LOW_RESET;
    hist_high       = 16'd0;
    hist_overflows  = 32'd0;
    hist_peak_slot  = 8'd0;
    hist_peak_level = 16'd0;
    hist_mean       = 16'd0;
  endtask

  // Applies one accepted word to the local histogram and queues the
  // statistics that its result word must carry.
  task automatic predict_stats(input flux_word_t w);
    flux_stats_t s;
    logic [15:0] slot_wide;
    logic [7:0]  slot;
    s.bin_count = 16'd0;
    case (w.op)
      OP_ADD: begin
        if (hist_samples != CNT_MAX) hist_samples++;
        if (w.interval < hist_low) hist_low = w.interval;
        if (w.interval > hist_high) hist_high = w.interval;
        // Anything that bins at or past the last bin is folded into it and
        // also counts as an overflow.
        slot_wide = w.interval >> SLOT_SHIFT;
        if (slot_wide >= 16'(LAST_BIN)) begin
          if (hist_overflows != CNT_MAX) hist_overflows++;
          slot = LAST_BIN;
        end else begin
          slot = slot_wide[7:0];
        end
        // A saturated bin stays put and cannot move the peak. The peak only
        // moves on a strictly greater count, so ties keep the older bin.
        if (hist_bins[slot] != BIN_MAX) begin
          hist_bins[slot]++;
          if (hist_bins[slot] > hist_peak_level) begin
            hist_peak_slot  = slot;
            hist_peak_level = hist_bins[slot];
          end
        end
        hist_mean = hist_mean - (hist_mean >> MEAN_SHIFT) + (w.interval >> MEAN_SHIFT);
      end
      OP_READ:  s.bin_count = hist_bins[w.bin_index];
      OP_CLEAR: clear_histogram();
      default: ;
    endcase
    s.sample_total      = hist_samples;
    s.shortest_interval = hist_low;
    s.longest_interval  = hist_high;
    s.overflow_total    = hist_overflows;
    s.peak_index        = hist_peak_slot;
    s.peak_value        = hist_peak_level;
    s.mean_estimate     = hist_mean;
    expected_stats.push_back(s);
  endtask

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver. A word stays on the port until it is taken; the gap that was
  // drawn for it runs only after it has been accepted, so valid never drops
  // under a stall.
  int         gap_left = 0;
  flux_word_t cur_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      quiet_phase <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_stats(cur_word);
        words_in <= words_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_queue.size() != 0 && word_queue[0].hold_for_drain) begin
          // Pause until the block has handed back everything it owes.
          in_valid <= 1'b0;
          if (expected_stats.size() == 0) void'(word_queue.pop_front());
        end else if (word_queue.size() != 0) begin
          cur_word = word_queue.pop_front();
          in_valid     <= 1'b1;
          in_opcode    <= cur_word.op;
          in_interval  <= cur_word.interval;
          in_bin_index <= cur_word.bin_index;
          quiet_phase  <= cur_word.quiet;
          gap_left = cur_word.quiet ? 0 : pick_idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, early in the random part, while
  // the driver keeps offering words. The block has to fill up and stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_in >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // Monitor. Checks each result word taken at this edge against the oldest
  // expectation, then decides the stall for the next cycle.
  int          stall_left = 0;
  flux_stats_t want;
  logic [31:0] got_f  [8];
  logic [31:0] want_f [8];
  string       field_name [8] = '{"bin_count", "sample_total", "shortest_interval",
                                  "longest_interval", "overflow_total", "peak_index",
                                  "peak_value", "mean_estimate"};

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected result word", 32'd0, 32'd0);
        end else begin
          want = expected_stats.pop_front();
          got_f  = '{32'(out_bin_count), out_sample_total, 32'(out_shortest_interval),
                     32'(out_longest_interval), out_overflow_total, 32'(out_peak_index),
                     32'(out_peak_value), 32'(out_mean_estimate)};
          want_f = '{32'(want.bin_count), want.sample_total, 32'(want.shortest_interval),
                     32'(want.longest_interval), want.overflow_total, 32'(want.peak_index),
                     32'(want.peak_value), 32'(want.mean_estimate)};
          for (int i = 0; i < 8; i++) begin
            if (got_f[i] !== want_f[i]) report_mismatch(field_name[i], got_f[i], want_f[i]);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (quiet_phase) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0) stall_left = pick_idle_len();
        if (stall_left != 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic push_word(input fih_op_t op, input logic [15:0] ivl,
                           input logic [7:0] idx, input logic quiet);
    flux_word_t w;
    w.op             = op;
    w.interval       = ivl;
    w.bin_index      = idx;
    w.quiet          = quiet;
    w.hold_for_drain = 1'b0;
    word_queue.push_back(w);
  endtask

  task automatic push_drain();
    flux_word_t w;
    w.op             = OP_NONE;
    w.interval       = 16'd0;
    w.bin_index      = 8'd0;
    w.quiet          = 1'b0;
    w.hold_for_drain = 1'b1;
    word_queue.push_back(w);
  endtask

  // Random word. Intervals lean toward the low bins so that counts pile up
  // and the peak moves, with boundary values around the last bin and the
  // whole 16-bit range mixed in. Reads favor bins that actually hold counts.
  task automatic push_random_word(input logic quiet);
    int          r;
    fih_op_t     op;
    logic [15:0] ivl;
    logic [7:0]  idx;
    r = $urandom_range(0, 99);
    if (r < 70)      op = OP_ADD;
    else if (r < 88) op = OP_READ;
    else if (r < 91) op = OP_CLEAR;
    else             op = OP_NONE;
    r = $urandom_range(0, 99);
    if (r < 30)      ivl = 16'($urandom_range(0, 63));
    else if (r < 55) ivl = 16'($urandom_range(0, 1100));
    else if (r < 65) ivl = 16'($urandom_range(1012, 1031));
    else if (r < 70) ivl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else             ivl = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 50)      idx = 8'($urandom_range(0, 16));
    else if (r < 70) idx = 8'($urandom_range(250, 255));
    else             idx = 8'($urandom_range(0, 255));
    push_word(op, ivl, idx, quiet);
  endtask

  task automatic push_random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 299) push_drain();
      // Every fifth block of sixty words runs with no idling on either side.
      push_random_word(((i / 60) % 5) == 3);
    end
  endtask

  initial begin
    clear_histogram();

    // Directed opening: reads of an empty store, the interval extremes, the
    // edge of the last bin, the unused opcode, clears, and peak ties.
    push_word(OP_READ,  16'h0000, 8'd0,     1'b0);
    push_word(OP_ADD,   16'd0,    8'h00,    1'b0);
    push_word(OP_ADD,   16'hFFFF, 8'h00,    1'b0);
    push_word(OP_ADD,   16'd1019, 8'h00,    1'b0);  // last ordinary bin
    push_word(OP_ADD,   16'd1020, 8'h00,    1'b0);  // first overflow value
    push_word(OP_ADD,   16'd1023, 8'h00,    1'b0);
    push_word(OP_READ,  16'h0000, LAST_BIN, 1'b0);
    push_word(OP_READ,  16'h0000, 8'd254,   1'b0);
    push_word(OP_NONE,  16'hAAAA, 8'h55,    1'b0);
    push_word(OP_CLEAR, 16'h5555, 8'hAA,    1'b0);
    push_word(OP_READ,  16'h0000, LAST_BIN, 1'b0);
    push_word(OP_ADD,   16'd8,    8'h00,    1'b0);  // bin 2 takes the peak
    push_word(OP_ADD,   16'd4,    8'h00,    1'b0);  // bin 1 ties, peak stays
    push_word(OP_ADD,   16'd5,    8'h00,    1'b0);  // bin 1 pulls ahead
    push_word(OP_ADD,   16'd10,   8'h00,    1'b0);  // bin 2 ties, peak stays
    push_word(OP_READ,  16'h0000, 8'd1,     1'b0);
    push_word(OP_READ,  16'h0000, 8'd2,     1'b0);
    push_word(OP_NONE,  16'h5555, 8'hFF,    1'b0);
    push_drain();
    push_word(OP_CLEAR, 16'hAAAA, 8'h55,    1'b0);
    push_word(OP_ADD,   16'hFFFF, 8'h00,    1'b0);
    push_word(OP_READ,  16'h0000, 8'hFF,    1'b0);

    push_random_run(800);

    // Burst: pile adds into one bin with no idling on either side, then
    // poke it and a neighbor to see that the count and the peak follow.
    push_drain();
    push_word(OP_CLEAR, 16'h0000, 8'h00, 1'b1);
    for (int i = 0; i < BURST_ADDS; i++)
      push_word(OP_ADD, 16'($urandom_range(400, 403)), 8'($urandom_range(0, 255)), 1'b1);
    push_word(OP_READ, 16'h0000, 8'd100, 1'b0);
    push_word(OP_ADD,  16'd401,  8'h00,  1'b0);
    push_word(OP_ADD,  16'd404,  8'h00,  1'b0);
    push_word(OP_READ, 16'h0000, 8'd100, 1'b0);
    push_word(OP_READ, 16'h0000, 8'd101, 1'b0);
    push_word(OP_CLEAR, 16'hFFFF, 8'hFF, 1'b0);

    push_random_run(800);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    // Go on clocking so that a stray extra result word would be seen.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hw/rtl/fih_pkg.sv
hw/rtl/fih_queue.sv
hw/rtl/fih_front.sv
hw/rtl/fih_back.sv
hw/rtl/flux_interval_histogram.sv
tb/sv/flux_interval_histogram_tb.sv
